// File: design/bpd_pkg.sv
`timescale 1ns / 1ps

package bpd_pkg;

   localparam int NUM_CHANNELS_DEF = 8;
   localparam int NUM_AXES_DEF     = 3;

   // Wide enough for the largest field count over the parameter range (1 + 16 + 4).
   localparam int FIELD_IDX_W = 5;
   localparam int OUT_IDX_W   = 4;
   localparam int CSR_ADDR_W  = 4;

   localparam logic [7:0]  HEADER_BYTE = 8'hA0;
   localparam logic [7:0]  FOOTER_BYTE = 8'hC0;

   localparam logic [31:0] CHANNEL_SCALE_RST = 32'd96000000;
   localparam logic [15:0] ACCEL_SCALE_RST   = 16'd2097;
   localparam logic [7:0]  JUMP_LIMIT_RST    = 8'd20;

   localparam logic [1:0] REG_CHANNEL_SCALE = 2'd0;
   localparam logic [1:0] REG_ACCEL_SCALE   = 2'd1;
   localparam logic [1:0] REG_JUMP_LIMIT    = 2'd2;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_SAMPLE,
      PH_CHAN,
      PH_ACCEL,
      PH_FOOT
   } phase_type;

   typedef enum logic [1:0] {
      KIND_SAMPLE,
      KIND_CHANNEL,
      KIND_ACCEL,
      KIND_RELEASE
   } item_kind_type;

   // A finished word (or a release mark) on its way to the field store.
   typedef struct packed {
      logic                   valid;
      item_kind_type          kind;
      logic [FIELD_IDX_W-1:0] idx;
      logic [23:0]            word;
   } word_item_type;

   typedef struct packed {
      logic                   valid;
      item_kind_type          kind;
      logic [FIELD_IDX_W-1:0] idx;
      logic [31:0]            data;
   } store_write_type;

endpackage

// File: design/bpd_scale.sv
`timescale 1ns / 1ps

module bpd_scale import bpd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  word_item_type   item,
   input  logic [31:0]     channel_scale,
   input  logic [15:0]     accel_scale,
   output store_write_type store_wr
);

   word_item_type        s2_ff;
   logic [31:0]          s2_val_ff;
   logic [31:0]          s2_val_in;
   logic                 s2_neg_ff;
   logic                 s2_neg_in;

   logic                 chan_neg;
   logic [23:0]          chan_mag;
   logic [55:0]          chan_prod;
   logic signed [32:0]   accel_prod;

   // Channel words are scaled as magnitudes so the shift truncates toward zero.
   always_comb begin
      chan_neg   = item.word[23];
      chan_mag   = chan_neg ? (~item.word + 24'd1) : item.word;
      chan_prod  = 56'(chan_mag) * 56'(channel_scale);
      accel_prod = $signed(item.word[15:0]) * $signed({1'b0, accel_scale});
      s2_neg_in  = 1'b0;
      case (item.kind)
         KIND_SAMPLE: begin
            s2_val_in = {24'd0, item.word[7:0]};
         end
         KIND_CHANNEL: begin
            s2_val_in = {8'd0, chan_prod[55:32]};
            s2_neg_in = chan_neg;
         end
         KIND_ACCEL: begin
            s2_val_in = accel_prod[31:0];
         end
         default: begin
            s2_val_in = 32'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.valid <= 1'b0;
      end else begin
         s2_ff.valid <= item.valid;
      end
      s2_ff.kind <= item.kind;
      s2_ff.idx  <= item.idx;
      s2_ff.word <= item.word;
      s2_val_ff  <= s2_val_in;
      s2_neg_ff  <= s2_neg_in;
   end

   always_comb begin
      store_wr.valid = s2_ff.valid;
      store_wr.kind  = s2_ff.kind;
      store_wr.idx   = s2_ff.idx;
      store_wr.data  = s2_neg_ff ? (32'd0 - s2_val_ff) : s2_val_ff;
   end

endmodule

// File: design/biosignal_packet_deframer.sv
`timescale 1ns / 1ps

// Channel  Direction  Ports                                      Beat
// req      in         req_valid, req_stall, req_data_byte        one received byte
// rsp      out        rsp_valid, rsp_stall, rsp_field_index,     one packet field
//                     rsp_field_value, rsp_last_field
// csr      in/out     APB: psel, penable, pwrite, paddr, pwdata, one register write or read
//                     prdata, pready
//
// A byte is taken every cycle while req_stall is low; a word reaches the field store
// through the item register and the s2 register of the scaling pipeline.
// A good footer starts the drain once its release mark leaves the scaling pipeline;
// fields leave via read and response registers, one per cycle while rsp_stall is low.
// req_stall rises only when a byte of the next packet would overwrite a store entry that
// the drain has not yet read; that store port interlock is the only input throttle.
// Reset is synchronous; it returns the parser to the header hunt and loads register
// defaults. The field store needs no clearing pass.

module biosignal_packet_deframer import bpd_pkg::*; #(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
   parameter int NUM_AXES     = NUM_AXES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_data_byte,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [OUT_IDX_W-1:0]  rsp_field_index,
   output logic signed [31:0]    rsp_field_value,
   output logic                  rsp_last_field,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int NUM_FIELDS = 1 + NUM_CHANNELS + NUM_AXES;
   localparam int AW         = $clog2(NUM_FIELDS);
   localparam int CW         = $clog2(NUM_CHANNELS + 1);
   localparam int XW         = $clog2(NUM_AXES + 1);

   // Configuration registers.
   logic [31:0] channel_scale_ff;
   logic [15:0] accel_scale_ff;
   logic [7:0]  jump_limit_ff;
   logic        csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_scale_ff <= CHANNEL_SCALE_RST;
         accel_scale_ff   <= ACCEL_SCALE_RST;
         jump_limit_ff    <= JUMP_LIMIT_RST;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            REG_CHANNEL_SCALE: channel_scale_ff <= csr_pwdata;
            REG_ACCEL_SCALE:   accel_scale_ff   <= csr_pwdata[15:0];
            REG_JUMP_LIMIT:    jump_limit_ff    <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_CHANNEL_SCALE: csr_prdata = channel_scale_ff;
         REG_ACCEL_SCALE:   csr_prdata = {16'd0, accel_scale_ff};
         REG_JUMP_LIMIT:    csr_prdata = {24'd0, jump_limit_ff};
         default:           csr_prdata = 32'd0;
      endcase
   end

   // Parser state.
   phase_type     phase_ff, phase_in;
   logic [1:0]    byte_cnt_ff, byte_cnt_in;
   logic [CW-1:0] chan_cnt_ff, chan_cnt_in;
   logic [XW-1:0] axis_cnt_ff, axis_cnt_in;
   logic [23:0]   word_ff, word_in;
   logic [7:0]    prev_sample_ff, prev_sample_in;
   word_item_type item_ff, item_in;

   logic                   req_accept;
   logic signed [9:0]      sample_diff;
   logic                   sample_drop;
   logic                   wr_pending;
   logic [FIELD_IDX_W-1:0] wr_idx;

   // Store side.
   store_write_type store_wr;
   logic [31:0]     field_mem [NUM_FIELDS];
   logic            drain_active_ff, drain_active_in;
   logic [AW-1:0]   drain_ptr_ff, drain_ptr_in;
   logic            rd_issue;
   logic            rd_valid_ff, rd_valid_in;
   logic [AW-1:0]   rd_idx_ff;
   logic            rd_last_ff;
   logic [31:0]     mem_q_ff;
   logic            rd_move;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [OUT_IDX_W-1:0] rsp_idx_ff;
   logic [31:0]     rsp_value_ff;
   logic            rsp_last_ff;
   logic            release_busy;
   logic            hazard;

   assign req_accept = req_valid && !req_stall;

   // The index that the current byte would write, from state alone.
   always_comb begin
      wr_pending = 1'b0;
      wr_idx     = '0;
      case (phase_ff)
         PH_SAMPLE: begin
            wr_pending = 1'b1;
         end
         PH_CHAN: begin
            wr_pending = (byte_cnt_ff == 2'd2);
            wr_idx     = FIELD_IDX_W'(1) + FIELD_IDX_W'(chan_cnt_ff);
         end
         PH_ACCEL: begin
            wr_pending = (byte_cnt_ff == 2'd1);
            wr_idx     = FIELD_IDX_W'(1 + NUM_CHANNELS) + FIELD_IDX_W'(axis_cnt_ff);
         end
         default: ;
      endcase
   end

   // A release still in the pipeline means a drain starting at pointer zero.
   assign release_busy = (item_ff.valid && item_ff.kind == KIND_RELEASE)
                      || (store_wr.valid && store_wr.kind == KIND_RELEASE);
   assign hazard       = (drain_active_ff || release_busy) && wr_pending
                      && (wr_idx >= FIELD_IDX_W'(drain_ptr_ff));
   assign req_stall    = hazard;

   assign sample_diff = $signed({2'b00, req_data_byte}) - $signed({2'b00, prev_sample_ff});
   assign sample_drop = (req_data_byte == prev_sample_ff)
                     || (sample_diff > $signed({2'b00, jump_limit_ff}));

   always_comb begin
      phase_in       = phase_ff;
      byte_cnt_in    = byte_cnt_ff;
      chan_cnt_in    = chan_cnt_ff;
      axis_cnt_in    = axis_cnt_ff;
      word_in        = word_ff;
      prev_sample_in = prev_sample_ff;
      item_in.valid  = 1'b0;
      item_in.kind   = KIND_SAMPLE;
      item_in.idx    = wr_idx;
      item_in.word   = {16'd0, req_data_byte};
      if (req_accept) begin
         case (phase_ff)
            PH_HUNT: begin
               if (req_data_byte == HEADER_BYTE) begin
                  phase_in    = PH_SAMPLE;
                  byte_cnt_in = 2'd0;
                  chan_cnt_in = '0;
                  axis_cnt_in = '0;
                  word_in     = 24'd0;
               end
            end
            PH_SAMPLE: begin
               byte_cnt_in = 2'd0;
               chan_cnt_in = '0;
               axis_cnt_in = '0;
               word_in     = 24'd0;
               if (sample_drop) begin
                  phase_in = PH_HUNT;
               end else begin
                  phase_in       = PH_CHAN;
                  prev_sample_in = req_data_byte;
                  item_in.valid  = 1'b1;
               end
            end
            PH_CHAN: begin
               word_in     = {word_ff[15:0], req_data_byte};
               byte_cnt_in = byte_cnt_ff + 2'd1;
               if (byte_cnt_ff == 2'd2) begin
                  item_in.valid = 1'b1;
                  item_in.kind  = KIND_CHANNEL;
                  item_in.word  = {word_ff[15:0], req_data_byte};
                  chan_cnt_in   = chan_cnt_ff + CW'(1);
                  byte_cnt_in   = 2'd0;
                  word_in       = 24'd0;
                  if (chan_cnt_ff == CW'(NUM_CHANNELS - 1)) begin
                     axis_cnt_in = '0;
                     phase_in    = PH_ACCEL;
                  end
               end
            end
            PH_ACCEL: begin
               word_in     = {8'd0, word_ff[7:0], req_data_byte};
               byte_cnt_in = byte_cnt_ff + 2'd1;
               if (byte_cnt_ff == 2'd1) begin
                  item_in.valid = 1'b1;
                  item_in.kind  = KIND_ACCEL;
                  item_in.word  = {8'd0, word_ff[7:0], req_data_byte};
                  axis_cnt_in   = axis_cnt_ff + XW'(1);
                  byte_cnt_in   = 2'd0;
                  word_in       = 24'd0;
                  if (axis_cnt_ff == XW'(NUM_AXES - 1)) begin
                     phase_in = PH_FOOT;
                  end
               end
            end
            PH_FOOT: begin
               phase_in    = PH_HUNT;
               byte_cnt_in = 2'd0;
               chan_cnt_in = '0;
               axis_cnt_in = '0;
               word_in     = 24'd0;
               if (req_data_byte == FOOTER_BYTE) begin
                  item_in.valid = 1'b1;
                  item_in.kind  = KIND_RELEASE;
               end
            end
            default: begin
               phase_in    = PH_HUNT;
               byte_cnt_in = 2'd0;
               chan_cnt_in = '0;
               axis_cnt_in = '0;
               word_in     = 24'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HUNT;
         byte_cnt_ff    <= 2'd0;
         chan_cnt_ff    <= '0;
         axis_cnt_ff    <= '0;
         word_ff        <= 24'd0;
         prev_sample_ff <= 8'd0;
         item_ff.valid  <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         byte_cnt_ff    <= byte_cnt_in;
         chan_cnt_ff    <= chan_cnt_in;
         axis_cnt_ff    <= axis_cnt_in;
         word_ff        <= word_in;
         prev_sample_ff <= prev_sample_in;
         item_ff.valid  <= item_in.valid;
      end
      item_ff.kind <= item_in.kind;
      item_ff.idx  <= item_in.idx;
      item_ff.word <= item_in.word;
   end

   bpd_scale u_scale (
      .clock         (clock),
      .reset         (reset),
      .item          (item_ff),
      .channel_scale (channel_scale_ff),
      .accel_scale   (accel_scale_ff),
      .store_wr      (store_wr)
   );

   // Drain: one read per cycle while the read stage has room.
   assign rd_move  = rd_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign rd_issue = drain_active_ff && (!rd_valid_ff || rd_move);

   always_comb begin
      drain_active_in = drain_active_ff;
      drain_ptr_in    = drain_ptr_ff;
      if (store_wr.valid && store_wr.kind == KIND_RELEASE) begin
         drain_active_in = 1'b1;
         drain_ptr_in    = '0;
      end else if (rd_issue) begin
         if (drain_ptr_ff == AW'(NUM_FIELDS - 1)) begin
            drain_active_in = 1'b0;
            drain_ptr_in    = '0;
         end else begin
            drain_ptr_in = drain_ptr_ff + AW'(1);
         end
      end
      rd_valid_in = rd_issue || (rd_valid_ff && !rd_move);
      if (rd_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // A read and a write of the same entry in one cycle return the old contents.
   always_ff @(posedge clock) begin
      if (store_wr.valid && store_wr.kind != KIND_RELEASE) begin
         field_mem[store_wr.idx[AW-1:0]] <= store_wr.data;
      end
      if (rd_issue) begin
         mem_q_ff <= field_mem[drain_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drain_active_ff <= 1'b0;
         drain_ptr_ff    <= '0;
         rd_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         drain_active_ff <= drain_active_in;
         drain_ptr_ff    <= drain_ptr_in;
         rd_valid_ff     <= rd_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      if (rd_issue) begin
         rd_idx_ff  <= drain_ptr_ff;
         rd_last_ff <= (drain_ptr_ff == AW'(NUM_FIELDS - 1));
      end
      if (rd_move) begin
         rsp_idx_ff   <= OUT_IDX_W'(rd_idx_ff);
         rsp_value_ff <= mem_q_ff;
         rsp_last_ff  <= rd_last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_field_index = rsp_idx_ff;
   assign rsp_field_value = $signed(rsp_value_ff);
   assign rsp_last_field  = rsp_last_ff;

   // A new packet never writes an entry that the drain has yet to read.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (store_wr.valid && store_wr.kind != KIND_RELEASE && drain_active_ff)
      |-> (store_wr.idx < FIELD_IDX_W'(drain_ptr_ff)))
      else $error("field store entry overwritten before drain read it");

   // Every entry is rewritten before the next footer, so drains never overlap.
   a_release_idle: assert property (@(posedge clock) disable iff (reset)
      (store_wr.valid && store_wr.kind == KIND_RELEASE) |-> !drain_active_ff)
      else $error("packet released while previous drain still reading");

   a_rd_hold: assert property (@(posedge clock) disable iff (reset)
      (rd_valid_ff && !rd_move) |=> (rd_valid_ff && $stable(mem_q_ff)))
      else $error("read stage lost data while held");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_field) |-> (rsp_field_index == OUT_IDX_W'(NUM_FIELDS - 1)))
      else $error("last field flag on wrong field index");

   a_issue_busy: assert property (@(posedge clock) disable iff (reset)
      rd_issue |-> !(store_wr.valid && store_wr.kind == KIND_RELEASE))
      else $error("drain read issued while a release was arriving");

endmodule
